FILE: design/pbfe_pkg.sv
package pbfe_pkg;

    localparam int BUF_DEPTH_DEF      = 256;
    localparam int MAX_FIELD_BITS_DEF = 64;

    localparam int SIZE_W  = 9;
    localparam int VALUE_W = 64;
    localparam int WIN_W   = 72;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_INSERT  = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_WIDE    = 2'd1;
    localparam logic [1:0] STAT_BIG     = 2'd2;
    localparam logic [1:0] STAT_OUTSIDE = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         byte_addr;
        logic [7:0]         byte_data;
        logic [7:0]         base_pointer;
        logic [10:0]        bit_offset;
        logic [6:0]         bit_count;
        logic [VALUE_W-1:0] insert_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] field_value;
        logic [3:0]         span_bytes;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EXT,
        S_INS,
        S_BYTE,
        S_DONE
    } t_state;

    // ones in the low cnt bits, all ones from 64 up
    function automatic logic [VALUE_W-1:0] field_mask(input logic [6:0] cnt);
        if (cnt >= 7'd64) begin
            return '1;
        end
        return (64'd1 << cnt) - 64'd1;
    endfunction

endpackage

FILE: design/packet_bit_field_engine_core.sv
// Channel   Direction  Handshake                      Word
// in        input      i_in_valid  / o_in_stall       t_in_item  (one request)
// out       output     o_out_valid / i_out_stall      t_out_item (one result)
// cfg       input      i_cfg_wr_en                    buffer_size, 9 bits
//
// A byte load writes in S_DECODE; a byte read is issued there, taken in S_BYTE.
// An extract first does a restoring shift-subtract wrap of the start
// address, then one buffer read a cycle through the single read port.
// An insert is a read-modify-write, one byte a cycle, pipelined.
// Reset sets buffer_size to 256; buffer contents are undefined until loaded.
// A new request is taken while a result waits; a finished request holds until
// the result register frees up.
module packet_bit_field_engine_core #(
    parameter int BUF_DEPTH      = pbfe_pkg::BUF_DEPTH_DEF,
    parameter int MAX_FIELD_BITS = pbfe_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbfe_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbfe_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [8:0]          i_cfg_wr_data
);
    import pbfe_pkg::*;

    localparam int AW       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int SIZE_CAP = (BUF_DEPTH > 511) ? 511 : BUF_DEPTH;
    localparam logic [SIZE_W-1:0] SIZE_CAP_W = SIZE_W'(SIZE_CAP);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [SIZE_W-1:0]  r_cfg_size;
    logic [SIZE_W-1:0]  r_num, n_num;
    logic [SIZE_W-1:0]  r_rem, n_rem;
    logic [3:0]         r_div_cnt, n_div_cnt;
    logic [SIZE_W-1:0]  r_addr, n_addr;
    logic [SIZE_W-1:0]  r_waddr, n_waddr;
    logic [3:0]         r_left, n_left;
    logic               r_pend, n_pend;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [WIN_W-1:0]   r_wmask, n_wmask;
    logic [VALUE_W-1:0] r_fmask, n_fmask;
    logic [2:0]         r_sh, n_sh;

    logic              w_rd_en, w_wr_en;
    logic [SIZE_W-1:0] w_rd_addr, w_wr_addr;
    logic [7:0]        w_wr_data;

    logic [SIZE_W-1:0]  w_size;
    logic [2:0]         w_s;
    logic [7:0]         w_span_sum;
    logic [4:0]         w_span;
    logic [3:0]         w_span_sat;
    logic [7:0]         w_boff;
    logic [VALUE_W-1:0] w_fmask;
    logic               w_cnt_wide;
    logic [6:0]         w_lshift;
    logic [7:0]         w_sh_full;
    logic               w_byte_out;
    logic               w_ins_out;
    logic [9:0]         w_div_trial;
    logic [SIZE_W-1:0]  w_div_rem;
    logic [SIZE_W-1:0]  w_addr_inc;
    logic               w_out_free;
    logic               w_ext_end, w_ins_end;

    assign w_size = (r_cfg_size == '0) ? SIZE_W'(1) :
                    ((r_cfg_size > SIZE_CAP_W) ? SIZE_CAP_W : r_cfg_size);

    assign w_s        = r_req.bit_offset[2:0];
    assign w_boff     = r_req.bit_offset[10:3];
    assign w_span_sum = {5'd0, w_s} + {1'b0, r_req.bit_count} + 8'd7;
    assign w_span     = w_span_sum[7:3];
    assign w_span_sat = (w_span > 5'd15) ? 4'd15 : w_span[3:0];
    assign w_fmask    = field_mask(r_req.bit_count);
    assign w_cnt_wide = 32'(r_req.bit_count) > MAX_FIELD_BITS;
    assign w_lshift   = 7'd72 - {4'd0, w_s} - r_req.bit_count;
    assign w_sh_full  = {w_span, 3'd0} - {5'd0, w_s} - {1'b0, r_req.bit_count};
    assign w_byte_out = {1'b0, r_req.byte_addr} >= w_size;
    // a field that covers no byte can never fall outside the buffer
    assign w_ins_out  = (w_span != 5'd0) &&
                        (({2'd0, w_boff} + {5'd0, w_span}) > {1'b0, w_size});

    assign w_div_trial = {r_rem, r_num[SIZE_W-1]};
    assign w_div_rem   = (w_div_trial >= {1'b0, w_size}) ?
                         SIZE_W'(w_div_trial - {1'b0, w_size}) : SIZE_W'(w_div_trial);
    assign w_addr_inc  = r_addr + SIZE_W'(1);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ext_end  = (r_left == 4'd0) && !r_pend;
    assign w_ins_end  = (r_left == 4'd0) && !r_pend;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_req.req_type)
                    REQ_READ: n_state = w_byte_out ? S_DONE : S_BYTE;
                    REQ_EXTRACT: begin
                        if (r_req.bit_count == 7'd0 || w_cnt_wide || w_span > 5'd8) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    REQ_INSERT: begin
                        if (w_cnt_wide || (r_req.insert_value & ~w_fmask) != '0 ||
                            w_ins_out || r_req.bit_count == 7'd0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_DIV: begin
                if (r_div_cnt == 4'd1) n_state = S_EXT;
            end
            S_EXT: begin
                if (w_ext_end) n_state = S_DONE;
            end
            S_INS: begin
                if (w_ins_end) n_state = S_DONE;
            end
            S_BYTE: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_num       = r_num;
        n_rem       = r_rem;
        n_div_cnt   = r_div_cnt;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_left      = r_left;
        n_pend      = r_pend;
        n_acc       = r_acc;
        n_win       = r_win;
        n_wmask     = r_wmask;
        n_fmask     = r_fmask;
        n_sh        = r_sh;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_waddr;
        w_wr_data   = (r_rdata & ~r_wmask[WIN_W-1 -: 8]) |
                      (r_win[WIN_W-1 -: 8] & r_wmask[WIN_W-1 -: 8]);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_req = i_in_data;
            end
            S_DECODE: begin
                n_res = '{field_value: '0, span_bytes: w_span_sat, status: STAT_OK};
                case (r_req.req_type)
                    REQ_LOAD: begin
                        if (w_byte_out) begin
                            n_res.span_bytes = 4'd0;
                            n_res.status     = STAT_OUTSIDE;
                        end else begin
                            w_wr_en          = 1'b1;
                            w_wr_addr        = SIZE_W'(r_req.byte_addr);
                            w_wr_data        = r_req.byte_data;
                            n_res.span_bytes = 4'd1;
                        end
                    end
                    REQ_READ: begin
                        if (w_byte_out) begin
                            n_res.span_bytes = 4'd0;
                            n_res.status     = STAT_OUTSIDE;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = SIZE_W'(r_req.byte_addr);
                        end
                    end
                    REQ_EXTRACT: begin
                        if (r_req.bit_count == 7'd0) begin
                            n_res.span_bytes = 4'd1;
                        end else if (w_cnt_wide || w_span > 5'd8) begin
                            n_res.status = STAT_WIDE;
                        end
                        n_num     = SIZE_W'(r_req.base_pointer) + SIZE_W'(w_boff);
                        n_rem     = '0;
                        n_div_cnt = 4'(SIZE_W);
                        n_fmask   = w_fmask;
                        n_sh      = w_sh_full[2:0];
                    end
                    REQ_INSERT: begin
                        if (w_cnt_wide) begin
                            n_res.status = STAT_WIDE;
                        end else if ((r_req.insert_value & ~w_fmask) != '0) begin
                            n_res.status = STAT_BIG;
                        end else if (w_ins_out) begin
                            n_res.status = STAT_OUTSIDE;
                        end
                        n_win   = {8'd0, r_req.insert_value} << w_lshift;
                        n_wmask = {8'd0, w_fmask} << w_lshift;
                        n_addr  = SIZE_W'(w_boff);
                        n_left  = w_span[3:0];
                        n_pend  = 1'b0;
                    end
                    default: n_res.status = STAT_OK;
                endcase
            end
            S_DIV: begin
                // one restoring step of (base + byte offset) mod size
                n_rem     = w_div_rem;
                n_num     = {r_num[SIZE_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt - 4'd1;
                if (r_div_cnt == 4'd1) begin
                    n_addr = w_div_rem;
                    n_left = w_span[3:0];
                    n_pend = 1'b0;
                end
            end
            S_EXT: begin
                if (r_pend) n_acc = {r_acc[VALUE_W-9:0], r_rdata};
                if (r_left != 4'd0) begin
                    w_rd_en = 1'b1;
                    n_addr  = (w_addr_inc == w_size) ? '0 : w_addr_inc;
                    n_left  = r_left - 4'd1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                n_res.field_value = (r_acc >> r_sh) & r_fmask;
            end
            S_INS: begin
                // write back the byte read last cycle, advance the window
                if (r_pend) begin
                    w_wr_en = 1'b1;
                    n_win   = r_win << 8;
                    n_wmask = r_wmask << 8;
                end
                if (r_left != 4'd0) begin
                    w_rd_en = 1'b1;
                    n_waddr = r_addr;
                    n_addr  = w_addr_inc;
                    n_left  = r_left - 4'd1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_BYTE: begin
                n_res.field_value = {56'd0, r_rdata};
                n_res.span_bytes  = 4'd1;
                n_res.status      = STAT_OK;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: n_pend = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_size  <= SIZE_RESET;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_wr_en) r_cfg_size <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_res     <= n_res;
        r_out     <= n_out;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_div_cnt <= n_div_cnt;
        r_addr    <= n_addr;
        r_waddr   <= n_waddr;
        r_left    <= n_left;
        r_acc     <= n_acc;
        r_win     <= n_win;
        r_wmask   <= n_wmask;
        r_fmask   <= n_fmask;
        r_sh      <= n_sh;
    end

    // packet buffer: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[AW'(w_wr_addr)] <= w_wr_data;
        if (w_rd_en) r_rdata <= r_mem[AW'(w_rd_addr)];
    end

endmodule
